/* hw/rtl/job_slot_table_assert.svh */
// ----------------------------------------------------------------------------
// job_slot_table_assert.svh
// assertion macros shared by the job slot table rtl
// ----------------------------------------------------------------------------
`ifndef JOB_SLOT_TABLE_ASSERT_SVH
`define JOB_SLOT_TABLE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define JST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define JST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/jst_pkg.sv */
// ----------------------------------------------------------------------------
// jst_pkg
// shared constants, codes and the token type that runs down the slot chain
// ----------------------------------------------------------------------------
package jst_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int ID_WIDTH   = 16;
  localparam int CMP_W      = (ID_WIDTH > 16) ? ID_WIDTH : 16;

  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [2:0]          req_t;
  typedef logic [1:0]          run_st_t;
  typedef logic [1:0]          status_t;

  localparam req_t REQ_ADD        = 3'd0;
  localparam req_t REQ_REMOVE     = 3'd1;
  localparam req_t REQ_FIND_ID    = 3'd2;
  localparam req_t REQ_FIND_GROUP = 3'd3;
  localparam req_t REQ_STOP       = 3'd4;
  localparam req_t REQ_CONT       = 3'd5;
  localparam req_t REQ_DONE       = 3'd6;

  localparam run_st_t ST_RUNNING = 2'd0;
  localparam run_st_t ST_STOPPED = 2'd1;
  localparam run_st_t ST_DONE    = 2'd2;

  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_FULL      = 2'd1;
  localparam status_t STAT_NOT_FOUND = 2'd2;

  localparam id_t ID_ONE = id_t'(1);
  localparam id_t ID_MAX = {ID_WIDTH{1'b1}};

  // request travelling down the chain, with the answer it picks up
  typedef struct packed {
    logic        valid;
    req_t        req;
    logic [15:0] job_number;
    logic [30:0] group;
    run_st_t     start_state;
    id_t         new_id;
    logic        hit;
    id_t         res_id;
    logic [30:0] res_group;
    run_st_t     res_state;
  } tok_t;

  // stored id against the 16-bit request id, compared at full width
  function automatic logic id_equal(input id_t id, input logic [15:0] jnum);
    return CMP_W'(id) == CMP_W'(jnum);
  endfunction

endpackage

/* hw/rtl/jst_cell.sv */
// ----------------------------------------------------------------------------
// jst_cell
// one job slot: matches the passing request, updates itself, forwards it
// ----------------------------------------------------------------------------
module jst_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  jst_pkg::tok_t tok_in,
  output jst_pkg::tok_t tok_out
);
  import jst_pkg::*;

  id_t         id_r, id_nxt;
  logic [30:0] group_r, group_nxt;
  run_st_t     state_r, state_nxt;
  tok_t        tok_r, tok_nxt;

  logic occupied;
  logic id_hit;
  logic grp_hit;
  logic take;

  always_comb begin
    occupied = (id_r != '0);
    id_hit   = occupied && id_equal(id_r, tok_in.job_number);
    grp_hit  = occupied && (group_r == tok_in.group);

    case (tok_in.req)
      REQ_ADD:                                   take = !occupied;
      REQ_REMOVE, REQ_FIND_ID:                   take = id_hit;
      REQ_FIND_GROUP, REQ_STOP, REQ_CONT, REQ_DONE: take = grp_hit;
      default:                                   take = 1'b0;
    endcase
    take = take && tok_in.valid && !tok_in.hit;

    id_nxt    = id_r;
    group_nxt = group_r;
    state_nxt = state_r;
    tok_nxt   = tok_in;

    if (take) begin
      case (tok_in.req)
        REQ_ADD: begin
          id_nxt    = tok_in.new_id;
          group_nxt = tok_in.group;
          state_nxt = tok_in.start_state;
        end
        REQ_REMOVE: begin
          id_nxt    = '0;
          group_nxt = '0;
          state_nxt = ST_DONE;
        end
        REQ_STOP: state_nxt = ST_STOPPED;
        REQ_CONT: state_nxt = ST_RUNNING;
        REQ_DONE: state_nxt = ST_DONE;
        default:  state_nxt = state_r;
      endcase

      tok_nxt.hit = 1'b1;
      if (tok_in.req == REQ_ADD) begin
        tok_nxt.res_id    = tok_in.new_id;
        tok_nxt.res_group = tok_in.group;
        tok_nxt.res_state = tok_in.start_state;
      end else begin
        tok_nxt.res_id    = id_r;
        tok_nxt.res_group = group_r;
        tok_nxt.res_state = state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r    <= '0;
      group_r <= '0;
      state_r <= ST_DONE;
      tok_r   <= '0;
    end else begin
      id_r    <= id_nxt;
      group_r <= group_nxt;
      state_r <= state_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

/* hw/rtl/job_slot_table.sv */
// ----------------------------------------------------------------------------
// job_slot_table
// fixed table of job slots with add, remove, lookup and run-state updates
// ----------------------------------------------------------------------------
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_ready, in_req_type, in_job_number,| sink
//          | in_group_number, in_start_state               |
//  out     | out_valid, out_ready, out_status, out_found_id,| source
//          | out_found_group, out_found_state,             |
//          | out_resume_signal                             |
//
//  - each transaction walks the chain of SLOT_COUNT slot cells, one cell a cycle
//  - one transaction is in the chain at a time: a new one is taken only
//    after the previous one has left the chain and the skid stage is empty
//  - the output register plus a one-entry skid stage let the next
//    transaction enter while a result still waits on out_ready
//  - synchronous reset frees every slot and sets the id counter to one
//
module job_slot_table (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_job_number,
  input  logic [30:0] in_group_number,
  input  logic [1:0]  in_start_state,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_found_id,
  output logic [30:0] out_found_group,
  output logic [1:0]  out_found_state,
  output logic        out_resume_signal
);
  import jst_pkg::*;

  `include "job_slot_table_assert.svh"

  // one finished answer as it leaves the block
  typedef struct packed {
    status_t     status;
    logic [15:0] found_id;
    logic [30:0] found_group;
    run_st_t     found_state;
    logic        resume;
  } res_t;

  tok_t tok [SLOT_COUNT+1];
  tok_t tok_head;

  logic busy_r, busy_nxt;
  id_t  id_cnt_r, id_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;

  logic    accept;
  logic    done;
  logic    pop;
  res_t    res;
  run_st_t start_fix;
  tok_t    last;

  // take a new request only with the chain empty and room for its answer
  assign in_ready = !busy_r && !skid_valid_r;
  assign accept   = in_valid && in_ready;

  // a start state of three is stored as done
  assign start_fix = (in_start_state == 2'd3) ? ST_DONE : run_st_t'(in_start_state);

  // injected straight into the first cell in the accepting cycle
  always_comb begin
    tok_head.valid       = accept;
    tok_head.req         = req_t'(in_req_type);
    tok_head.job_number  = in_job_number;
    tok_head.group       = in_group_number;
    tok_head.start_state = start_fix;
    tok_head.new_id      = id_cnt_r;
    tok_head.hit         = 1'b0;
    tok_head.res_id      = '0;
    tok_head.res_group   = '0;
    tok_head.res_state   = ST_RUNNING;
  end

  assign tok[0] = tok_head;

  // the slot chain: lowest slot sees the request first, so it wins
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
    jst_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  assign last = tok[SLOT_COUNT];
  assign done = last.valid;
  assign pop  = out_valid_r && out_ready;

  // shape the answer; failures carry zero fields
  always_comb begin
    if (last.hit) begin
      res.status      = STAT_OK;
      res.found_id    = 16'(last.res_id);
      res.found_group = last.res_group;
      res.found_state = last.res_state;
      res.resume      = (last.req == REQ_CONT);
    end else begin
      res.status      = (last.req == REQ_ADD) ? STAT_FULL : STAT_NOT_FOUND;
      res.found_id    = '0;
      res.found_group = '0;
      res.found_state = ST_RUNNING;
      res.resume      = 1'b0;
    end
  end

  always_comb begin
    busy_nxt       = busy_r;
    id_cnt_nxt     = id_cnt_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;

    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (done) begin
      busy_nxt = 1'b0;
      // counter advances only when an add found a free slot, wrapping to one
      if (last.req == REQ_ADD && last.hit) begin
        id_cnt_nxt = (id_cnt_r == ID_MAX) ? ID_ONE : id_cnt_r + ID_ONE;
      end
    end

    // output register with a one-deep skid behind it
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = done;
      end else begin
        out_nxt       = res;
        out_valid_nxt = done;
      end
    end else if (done) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      id_cnt_r     <= ID_ONE;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      id_cnt_r     <= id_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_found_id      = out_r.found_id;
  assign out_found_group   = out_r.found_group;
  assign out_found_state   = out_r.found_state;
  assign out_resume_signal = out_r.resume;

  // an accepted transaction occupies the chain
  `JST_ASSERT_NEXT(a_accept_busy, accept, busy_r, "accepted transaction left chain idle")
  // a result only leaves the chain while a transaction is in flight
  `JST_ASSERT_SAME(a_done_busy, done, busy_r, "result emerged with no transaction in flight")
  // skid stage only fills behind a held output
  `JST_ASSERT_SAME(a_skid_order, skid_valid_r, out_valid_r, "skid holds data ahead of output")
  // a finished transaction always lands in the output path
  `JST_ASSERT_NEXT(a_done_lands, done, out_valid_r, "finished result was dropped")

endmodule
